// ===== rtl/assert_macros.svh =====
// Assertion shorthands used by the checker in bspl_chk.sv.
// Each takes a label, an antecedent, a consequent and a message string.
// The sampling clock is clk; checks are off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CHK_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bspl_pkg.sv =====
`default_nettype none
package bspl_pkg;

  localparam int TABLE_DEPTH   = 4096;
  localparam int ADDR_W        = 12;
  localparam int CHILD_W       = 13;
  localparam int COUNT_W       = 13;
  localparam int LEAF_BIT      = 12;
  localparam int FIX_W         = 32;
  localparam int HI_W          = 16;
  localparam int PROD_W        = FIX_W + HI_W;
  localparam int MAX_NODES_DEF = 4096;

  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_LOCATE = 1'b1;

  // partition line geometry, 16.16 fixed point
  typedef struct packed {
    logic signed [FIX_W-1:0] x;
    logic signed [FIX_W-1:0] y;
    logic signed [FIX_W-1:0] dx;
    logic signed [FIX_W-1:0] dy;
  } bspl_line_t;

  // one table entry: line plus children (bit 12 = leaf flag)
  typedef struct packed {
    bspl_line_t         line;
    logic [CHILD_W-1:0] front;
    logic [CHILD_W-1:0] back;
  } bspl_node_t;

  // side test status toward the walk controller
  typedef struct packed {
    logic done;
    logic side;
  } bspl_side_res_t;

endpackage
`default_nettype wire

// ===== rtl/bsp_point_locate_core.sv =====
// Channel | Dir | Handshake             | Beat contents
// in_     | in  | in_valid / in_ready   | action, node_index, line, children, point
// out_    | out | out_valid / out_ready | leaf_index, walk_error
// cfg_    | in  | cfg_valid / cfg_ready | node_count (always ready)
//
// A write beat goes straight to the table; in_ready stays high.
// A locate beat holds in_ready low until its walk ends: per node visited one
// check, one node-table read and three side-test stages, then a last check and
// emit, which waits on the output register; at most MAX_NODES node visits.
// Reset (rst_n low, synchronous) clears control and node_count, not the table.
// A result waits in the output register while the next beat is taken; a newer
// result holds in the walker (in_ready low) until out_ready frees the register.
`default_nettype none
module bsp_point_locate_core
  import bspl_pkg::*;
#(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  // node write / locate beats
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic                    in_action,
  input  wire logic [ADDR_W-1:0]       in_node_index,
  input  wire logic signed [FIX_W-1:0] in_line_x,
  input  wire logic signed [FIX_W-1:0] in_line_y,
  input  wire logic signed [FIX_W-1:0] in_line_dx,
  input  wire logic signed [FIX_W-1:0] in_line_dy,
  input  wire logic [CHILD_W-1:0]      in_front_child,
  input  wire logic [CHILD_W-1:0]      in_back_child,
  input  wire logic signed [FIX_W-1:0] in_point_x,
  input  wire logic signed [FIX_W-1:0] in_point_y,
  // results
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [ADDR_W-1:0]            out_leaf_index,
  output logic                         out_walk_error,
  // node count register
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [COUNT_W-1:0]      cfg_node_count
);

  localparam int STEP_W = $clog2(MAX_NODES + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_SIDE  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0]              state_r, state_nxt;
  logic [COUNT_W-1:0]      node_count_r;
  logic [CHILD_W-1:0]      cur_r, cur_nxt;
  logic [STEP_W-1:0]       steps_r, steps_nxt;
  logic signed [FIX_W-1:0] px_r, px_nxt, py_r, py_nxt;
  logic [ADDR_W-1:0]       res_leaf_r, res_leaf_nxt;
  logic                    res_err_r, res_err_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]       out_leaf_r;
  logic                    out_err_r;

  logic           in_accept;
  logic           out_load;
  logic           wr_en;
  logic           rd_en;
  logic           side_start;
  bspl_node_t     wr_node;
  bspl_node_t     rd_node;
  bspl_side_res_t side_res;

  assign in_ready  = (state_r == S_IDLE);
  assign in_accept = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // writes go straight to the table on the accepting edge
  assign wr_en         = in_accept && (in_action == ACT_WRITE);
  assign wr_node.line  = '{x: in_line_x, y: in_line_y, dx: in_line_dx, dy: in_line_dy};
  assign wr_node.front = in_front_child;
  assign wr_node.back  = in_back_child;

  bspl_node_mem u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (in_node_index),
    .wr_data (wr_node),
    .rd_en   (rd_en),
    .rd_addr (cur_r[ADDR_W-1:0]),
    .rd_data (rd_node)
  );

  bspl_side u_side (
    .clk   (clk),
    .rst_n (rst_n),
    .start (side_start),
    .line  (rd_node.line),
    .px    (px_r),
    .py    (py_r),
    .res   (side_res)
  );

  // walk sequencer
  always_comb begin
    state_nxt    = state_r;
    cur_nxt      = cur_r;
    steps_nxt    = steps_r;
    px_nxt       = px_r;
    py_nxt       = py_r;
    res_leaf_nxt = res_leaf_r;
    res_err_nxt  = res_err_r;
    rd_en        = 1'b0;
    side_start   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_accept && (in_action == ACT_LOCATE)) begin
          px_nxt    = in_point_x;
          py_nxt    = in_point_y;
          steps_nxt = '0;
          if (node_count_r == '0) begin
            // empty tree: leaf 0, no error
            res_leaf_nxt = '0;
            res_err_nxt  = 1'b0;
            state_nxt    = S_EMIT;
          end else begin
            cur_nxt   = node_count_r - COUNT_W'(1);
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (cur_r[LEAF_BIT]) begin
          // a root at or above 4096 also lands here as a leaf
          res_leaf_nxt = cur_r[ADDR_W-1:0];
          res_err_nxt  = 1'b0;
          state_nxt    = S_EMIT;
        end else if ((cur_r >= node_count_r) || (steps_r >= STEP_W'(MAX_NODES))) begin
          res_leaf_nxt = '0;
          res_err_nxt  = 1'b1;
          state_nxt    = S_EMIT;
        end else begin
          rd_en     = 1'b1;
          steps_nxt = steps_r + STEP_W'(1);
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        side_start = 1'b1;
        state_nxt  = S_SIDE;
      end
      S_SIDE: begin
        if (side_res.done) begin
          cur_nxt   = side_res.side ? rd_node.back : rd_node.front;
          state_nxt = S_CHECK;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output register
  assign out_load = (state_r == S_EMIT) && (!out_valid_r || out_ready);

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      node_count_r <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        node_count_r <= cfg_node_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    steps_r    <= steps_nxt;
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    res_leaf_r <= res_leaf_nxt;
    res_err_r  <= res_err_nxt;
    if (out_load) begin
      out_leaf_r <= res_leaf_r;
      out_err_r  <= res_err_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_leaf_index = out_leaf_r;
  assign out_walk_error = out_err_r;

endmodule
`default_nettype wire

// ===== rtl/bspl_node_mem.sv =====
`default_nettype none
module bspl_node_mem
  import bspl_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire bspl_node_t        wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output bspl_node_t             rd_data
);

  bspl_node_t mem_r [TABLE_DEPTH];
  bspl_node_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read, data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ===== rtl/bspl_side.sv =====
`default_nettype none
module bspl_side
  import bspl_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire bspl_line_t              line,
  input  wire logic signed [FIX_W-1:0] px,
  input  wire logic signed [FIX_W-1:0] py,
  output bspl_side_res_t               res
);

  // stage 1: offsets, axis-aligned and sign shortcut cases
  logic                    v1_r, v2_r, v3_r;
  logic                    early1_r, early2_r;
  logic                    eside1_r, eside2_r;
  logic signed [FIX_W-1:0] ex_r, ey_r;
  logic signed [HI_W-1:0]  dy_hi_r, dx_hi_r;
  // stage 2: products
  logic signed [PROD_W-1:0] left_p_r, right_p_r;
  // stage 3: result
  logic                    side_r;

  logic                    early_nxt, eside_nxt;
  logic signed [FIX_W-1:0] ex_nxt, ey_nxt;
  logic                    side_nxt;
  logic signed [PROD_W-1:0] left_p_nxt, right_p_nxt;

  always_comb begin
    ex_nxt    = px - line.x;
    ey_nxt    = py - line.y;
    early_nxt = 1'b1;
    eside_nxt = 1'b0;
    if (line.dx == '0) begin
      eside_nxt = (px <= line.x) ? (line.dy > 0) : (line.dy < 0);
    end else if (line.dy == '0) begin
      eside_nxt = (py <= line.y) ? (line.dx < 0) : (line.dx > 0);
    end else if (line.dy[FIX_W-1] ^ line.dx[FIX_W-1] ^ ex_nxt[FIX_W-1] ^ ey_nxt[FIX_W-1]) begin
      eside_nxt = line.dy[FIX_W-1] ^ ex_nxt[FIX_W-1];
    end else begin
      early_nxt = 1'b0;
    end
  end

  assign left_p_nxt  = dy_hi_r * ex_r;
  assign right_p_nxt = ey_r * dx_hi_r;

  always_comb begin
    if (early2_r) begin
      side_nxt = eside2_r;
    end else begin
      side_nxt = !($signed(right_p_r[PROD_W-1:HI_W]) < $signed(left_p_r[PROD_W-1:HI_W]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    ex_r      <= ex_nxt;
    ey_r      <= ey_nxt;
    dy_hi_r   <= line.dy[FIX_W-1:HI_W];
    dx_hi_r   <= line.dx[FIX_W-1:HI_W];
    early1_r  <= early_nxt;
    eside1_r  <= eside_nxt;
    left_p_r  <= left_p_nxt;
    right_p_r <= right_p_nxt;
    early2_r  <= early1_r;
    eside2_r  <= eside1_r;
    side_r    <= side_nxt;
  end

  assign res.done = v3_r;
  assign res.side = side_r;

endmodule
`default_nettype wire

// ===== rtl/bspl_chk.sv =====
`default_nettype none
`include "assert_macros.svh"
module bspl_chk
  import bspl_pkg::*;
(
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    in_valid,
  input wire logic                    in_ready,
  input wire logic                    in_action,
  input wire logic                    out_valid,
  input wire logic                    out_ready,
  input wire logic [ADDR_W-1:0]       out_leaf_index,
  input wire logic                    out_walk_error
);

  // stalled result beat holds
  `CHK_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_leaf_index) && $stable(out_walk_error), "stalled result beat changed")

  // a failed walk always reports leaf 0
  `CHK_SAME(a_err_leaf0, out_valid && out_walk_error, out_leaf_index == '0, "walk error with nonzero leaf")

  // a locate beat occupies the walker
  `CHK_NEXT(a_locate_busy, in_valid && in_ready && (in_action == ACT_LOCATE), !in_ready, "input ready right after a locate beat")

  // a write beat keeps in_ready high into the next cycle
  `CHK_NEXT(a_write_fast, in_valid && in_ready && (in_action == ACT_WRITE), in_ready, "input not ready after a write beat")

endmodule

bind bsp_point_locate_core bspl_chk u_bspl_chk (.*);
`default_nettype wire

// ===== verif/bspl_locate_checker.sv =====
`timescale 1ns / 100ps
module bspl_locate_checker
  import bspl_pkg::*;
#(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic                    in_action,
  input  logic [ADDR_W-1:0]       in_node_index,
  input  logic signed [FIX_W-1:0] in_line_x,
  input  logic signed [FIX_W-1:0] in_line_y,
  input  logic signed [FIX_W-1:0] in_line_dx,
  input  logic signed [FIX_W-1:0] in_line_dy,
  input  logic [CHILD_W-1:0]      in_front_child,
  input  logic [CHILD_W-1:0]      in_back_child,
  input  logic signed [FIX_W-1:0] in_point_x,
  input  logic signed [FIX_W-1:0] in_point_y,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic [ADDR_W-1:0]       out_leaf_index,
  input  logic                    out_walk_error,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [COUNT_W-1:0]      cfg_node_count,
  output int                      locates_pending,
  output int                      mismatch_count
);

  typedef struct packed {
    logic [ADDR_W-1:0] leaf;
    logic              walk_err;
  } leaf_result_t;

  bspl_node_t         node_mem [TABLE_DEPTH];
  logic [COUNT_W-1:0] node_count_q;
  leaf_result_t       expected_leaves [$];
  int                 mismatches;

  // 0 = front, 1 = back
  function automatic logic side_of_line(bspl_line_t ln, logic signed [FIX_W-1:0] px,
                                        logic signed [FIX_W-1:0] py);
    logic signed [FIX_W-1:0] lx, ly, ldx, ldy, ex, ey, dy_hi, dx_hi;
    logic signed [63:0]      a, b, lhs, rhs;
    lx  = ln.x;
    ly  = ln.y;
    ldx = ln.dx;
    ldy = ln.dy;
    if (ldx == 0) return (px <= lx) ? (ldy > 0) : (ldy < 0);
    if (ldy == 0) return (py <= ly) ? (ldx < 0) : (ldx > 0);
    ex = px - lx;
    ey = py - ly;
    // quick sign decision when the two products must differ in sign
    if (ldy[FIX_W-1] ^ ldx[FIX_W-1] ^ ex[FIX_W-1] ^ ey[FIX_W-1])
      return ldy[FIX_W-1] ^ ex[FIX_W-1];
    dy_hi = ldy >>> HI_W;
    dx_hi = ldx >>> HI_W;
    a   = dy_hi;
    b   = ex;
    lhs = (a * b) >>> HI_W;
    a   = ey;
    b   = dx_hi;
    rhs = (a * b) >>> HI_W;
    return (rhs < lhs) ? 1'b0 : 1'b1;
  endfunction

  function automatic leaf_result_t walk_tree(logic signed [FIX_W-1:0] px,
                                             logic signed [FIX_W-1:0] py);
    leaf_result_t       res;
    logic [CHILD_W-1:0] cur;
    int                 steps;
    bspl_node_t         n;
    res = '0;
    if (node_count_q == 0) return res;
    cur   = node_count_q - 1'b1;
    steps = 0;
    while (!cur[LEAF_BIT]) begin
      // index past the count, or walk over the step budget
      if (cur >= node_count_q || steps >= MAX_NODES) begin
        res.walk_err = 1'b1;
        return res;
      end
      steps++;
      n   = node_mem[cur[ADDR_W-1:0]];
      cur = side_of_line(n.line, px, py) ? n.back : n.front;
    end
    res.leaf = cur[ADDR_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin : monitor
    leaf_result_t got, want;
    bspl_node_t   entry;
    if (!rst_n) begin
      node_count_q = '0;
      expected_leaves.delete();
    end else begin
      if (cfg_valid && cfg_ready) node_count_q = cfg_node_count;

      if (out_valid && out_ready) begin
        got.leaf     = out_leaf_index;
        got.walk_err = out_walk_error;
        if (expected_leaves.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result beat leaf_index %0d walk_error %0b",
                     $time, got.leaf, got.walk_err);
        end else begin
          want = expected_leaves.pop_front();
          if (got.leaf != want.leaf || got.walk_err != want.walk_err) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch leaf_index exp %0d got %0d, walk_error exp %0b got %0b",
                       $time, want.leaf, got.leaf, want.walk_err, got.walk_err);
          end
        end
      end

      if (in_valid && in_ready) begin
        if (in_action == ACT_WRITE) begin
          entry.line.x  = in_line_x;
          entry.line.y  = in_line_y;
          entry.line.dx = in_line_dx;
          entry.line.dy = in_line_dy;
          entry.front   = in_front_child;
          entry.back    = in_back_child;
          node_mem[in_node_index] = entry;
        end else begin
          expected_leaves.push_back(walk_tree(in_point_x, in_point_y));
        end
      end
    end
    locates_pending <= expected_leaves.size();
    mismatch_count  <= mismatches;
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
module tb_top;
  import bspl_pkg::*;

  localparam int ITEM_TARGET = 1850;
  localparam int CYCLE_LIMIT = 4_000_000;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic                    in_action;
  logic [ADDR_W-1:0]       in_node_index;
  logic signed [FIX_W-1:0] in_line_x;
  logic signed [FIX_W-1:0] in_line_y;
  logic signed [FIX_W-1:0] in_line_dx;
  logic signed [FIX_W-1:0] in_line_dy;
  logic [CHILD_W-1:0]      in_front_child;
  logic [CHILD_W-1:0]      in_back_child;
  logic signed [FIX_W-1:0] in_point_x;
  logic signed [FIX_W-1:0] in_point_y;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [ADDR_W-1:0]       out_leaf_index;
  logic                    out_walk_error;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [COUNT_W-1:0]      cfg_node_count;

  int locates_pending;
  int mismatch_count;

  // Stimulus-side bookkeeping. A walk must never read an entry that was
  // never written, so each non-leaf child from pick_child points at an entry
  // already written and below its parent, so random trees stay acyclic.
  bit node_written [TABLE_DEPTH];
  int beats_sent;
  int burst_left;
  bit gaps_on;
  int cycle_count;
  int stall_mode;
  int stall_left;

  bsp_point_locate_core uut (.*);

  bspl_locate_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL bsp_point_locate_core");
      $finish;
    end
  end

  // Result-side back-pressure: modes of random length - always ready,
  // mostly ready, mostly stalled, and a fixed 2-of-7 duty pattern.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(16, 256);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(0, 3) != 0);
      2:       out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= ((stall_left % 7) < 2);
    endcase
  end

  function automatic bspl_line_t line_of(logic signed [FIX_W-1:0] x,
                                         logic signed [FIX_W-1:0] y,
                                         logic signed [FIX_W-1:0] dx,
                                         logic signed [FIX_W-1:0] dy);
    bspl_line_t ln;
    ln.x  = x;
    ln.y  = y;
    ln.dx = dx;
    ln.dy = dy;
    return ln;
  endfunction

  function automatic logic [CHILD_W-1:0] leaf_ref(logic [ADDR_W-1:0] idx);
    return {1'b1, idx};
  endfunction

  function automatic logic [CHILD_W-1:0] node_ref(logic [ADDR_W-1:0] idx);
    return {1'b0, idx};
  endfunction

  // 16.16 values weighted toward extremes, small offsets and whole numbers
  function automatic logic signed [FIX_W-1:0] rand_fix();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return $urandom_range(0, 'h3FFFF) - 'h20000;
      3:       return {16'($urandom_range(0, 15) - 8), 16'h0000};
      default: return $urandom();
    endcase
  endfunction

  // random line, with vertical and horizontal ones forced now and then
  function automatic bspl_line_t rand_line();
    bspl_line_t ln;
    ln = line_of(rand_fix(), rand_fix(), rand_fix(), rand_fix());
    case ($urandom_range(0, 5))
      0:       ln.dx = '0;
      1:       ln.dy = '0;
      default: ;
    endcase
    return ln;
  endfunction

  // Child of node 'own': a leaf, or an already-written node a little below.
  function automatic logic [CHILD_W-1:0] pick_child(int own);
    int t;
    if (own > 0 && $urandom_range(0, 99) < 55) begin
      repeat (6) begin
        t = own - $urandom_range(1, (own < 48) ? own : 48);
        if (node_written[t]) return node_ref(12'(t));
      end
    end
    return leaf_ref(12'($urandom()));
  endfunction

  // One input beat. Returns in the step of acceptance without touching
  // in_valid unless a gap follows, so a back-to-back beat keeps valid high.
  task automatic push_beat(input logic act, input logic [ADDR_W-1:0] idx,
                           input bspl_line_t ln, input logic [CHILD_W-1:0] fr,
                           input logic [CHILD_W-1:0] bk,
                           input logic signed [FIX_W-1:0] px,
                           input logic signed [FIX_W-1:0] py);
    in_valid       <= 1'b1;
    in_action      <= act;
    in_node_index  <= idx;
    in_line_x      <= ln.x;
    in_line_y      <= ln.y;
    in_line_dx     <= ln.dx;
    in_line_dy     <= ln.dy;
    in_front_child <= fr;
    in_back_child  <= bk;
    in_point_x     <= px;
    in_point_y     <= py;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
    if (act == ACT_WRITE) node_written[idx] = 1'b1;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  endtask

  // point fields carry noise on a write beat
  task automatic write_node(input logic [ADDR_W-1:0] idx, input bspl_line_t ln,
                            input logic [CHILD_W-1:0] fr, input logic [CHILD_W-1:0] bk);
    push_beat(ACT_WRITE, idx, ln, fr, bk, rand_fix(), rand_fix());
  endtask

  // node fields carry noise on a locate beat
  task automatic locate(input logic signed [FIX_W-1:0] px,
                        input logic signed [FIX_W-1:0] py);
    push_beat(ACT_LOCATE, 12'($urandom()), rand_line(), 13'($urandom()),
              13'($urandom()), px, py);
  endtask

  task automatic write_rand_node(input int idx);
    write_node(12'(idx), rand_line(), pick_child(idx), pick_child(idx));
  endtask

  // node_count changes only with the block idle: every locate answered,
  // then a pause so a trailing write beat can settle.
  task automatic set_node_count(input logic [COUNT_W-1:0] value);
    in_valid <= 1'b0;
    do @(posedge clk); while (locates_pending != 0);
    repeat (8) @(posedge clk);
    cfg_valid      <= 1'b1;
    cfg_node_count <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int count;
    int span;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_action      <= ACT_WRITE;
    in_node_index  <= '0;
    in_line_x      <= '0;
    in_line_y      <= '0;
    in_line_dx     <= '0;
    in_line_dy     <= '0;
    in_front_child <= '0;
    in_back_child  <= '0;
    in_point_x     <= '0;
    in_point_y     <= '0;
    cfg_valid      <= 1'b0;
    cfg_node_count <= '0;
    gaps_on    = 1'b1;
    burst_left = $urandom_range(1, 24);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // ---- directed ----
    // empty tree, straight out of reset and after an explicit zero
    locate(32'h7FFF_FFFF, 32'h8000_0000);
    set_node_count(13'd0);
    locate(32'h0, 32'h0);

    // single node: vertical line, point on, right of, far left of it
    write_node(12'd0, line_of(32'h0, 32'h0, 32'h0, 32'h0001_0000),
               leaf_ref(12'h001), leaf_ref(12'hFFF));
    set_node_count(13'd1);
    locate(32'h0, 32'h0000_0005);
    locate(32'h0000_0001, 32'h0);
    locate(32'h8000_0000, 32'h0);

    // horizontal line with extreme direction, point on and above
    write_node(12'd0, line_of(32'h7FFF_FFFF, 32'hFFFF_0000, 32'h8000_0000, 32'h0),
               leaf_ref(12'h000), leaf_ref(12'hABC));
    locate(32'h0, 32'hFFFF_0000);
    locate(32'h0, 32'h7FFF_FFFF);

    // general line: sign shortcut, product compare, and a tie
    write_node(12'd0, line_of(32'h0001_0000, 32'hFFFF_0000, 32'h0003_0000, 32'hFFFE_0000),
               leaf_ref(12'h010), leaf_ref(12'h020));
    locate(32'h8000_0000, 32'h7FFF_FFFF);
    locate(32'h0002_0000, 32'hFFFF_0000);
    locate(32'h0002_0000, 32'hFFFE_0000);
    locate(32'h0004_0000, 32'hFFFD_0000);

    // child index past node_count -> walk error
    write_node(12'd5, line_of(32'h0, 32'h0, 32'h0, 32'h0), leaf_ref(12'h005), leaf_ref(12'h006));
    write_node(12'd0, line_of(32'h0, 32'h0, 32'h0000_0001, 32'h0000_0001),
               node_ref(12'd5), node_ref(12'd5));
    locate(32'h0, 32'h0);

    // node pointing at itself -> step budget runs out
    write_node(12'd0, line_of(32'h0, 32'h0, 32'h0, 32'h0), node_ref(12'd0), node_ref(12'd0));
    locate(32'h0, 32'h0);

    // top entry as root; node 0 made harmless again for the random part
    write_node(12'hFFF, line_of(32'h0, 32'h0, 32'h0001_0000, 32'h0),
               node_ref(12'd5), leaf_ref(12'hFFF));
    write_node(12'd0, line_of(32'h0, 32'h0, 32'h0, 32'h0), leaf_ref(12'h000), leaf_ref(12'h000));
    set_node_count(13'(TABLE_DEPTH));
    locate(32'h0, 32'h8000_0000);
    locate(32'h0, 32'h0000_0001);

    // count beyond the table: the root index itself carries the leaf flag
    set_node_count(13'h1FFF);
    locate(rand_fix(), rand_fix());

    // ---- random ----
    // Each phase: new count, a tree grown under the root when the count fits the
    // table, then mostly locates with some node rewrites mixed in.
    while (beats_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 11))
        0:       count = 0;
        1:       count = 1;
        2:       count = TABLE_DEPTH;
        3:       count = $urandom_range(TABLE_DEPTH + 1, 8191);
        4, 5, 6: count = $urandom_range(2, 16);
        7, 8, 9: count = $urandom_range(17, 300);
        default: count = $urandom_range(301, TABLE_DEPTH - 1);
      endcase
      set_node_count(13'(count));
      gaps_on = ($urandom_range(0, 3) != 0);
      if (count >= 1 && count <= TABLE_DEPTH) begin
        span = $urandom_range(4, 40);
        // dense window just below the root so walks go several levels deep
        repeat (span)
          write_rand_node(count - 1 -
                          $urandom_range(0, (count - 1 < 4 * span) ? count - 1 : 4 * span));
        write_rand_node(count - 1);
      end
      repeat ($urandom_range(20, 80)) begin
        if ($urandom_range(0, 4) == 0) write_rand_node($urandom_range(0, TABLE_DEPTH - 1));
        else locate(rand_fix(), rand_fix());
      end
    end

    // ---- drain ----
    in_valid <= 1'b0;
    do @(posedge clk); while (locates_pending != 0);
    repeat (64) @(posedge clk);
    if (mismatch_count == 0 && locates_pending == 0) begin
      $display("PASS bsp_point_locate_core");
    end else begin
      $display("FAIL bsp_point_locate_core");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/bspl_pkg.sv
rtl/bspl_node_mem.sv
rtl/bspl_side.sv
rtl/bsp_point_locate_core.sv
rtl/bspl_chk.sv
verif/bspl_locate_checker.sv
verif/tb_top.sv
